### hdl/etl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

   // position, line and column width
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   localparam int KIND_BITS = 5;

   // token queue toward the receiver
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_END    = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_LETTER = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_COLON  = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_LBRACK = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_RBRACK = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_DOT    = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_PLUS   = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_MINUS  = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_STAR   = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_SLASH  = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_PCT    = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_CARET  = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_LT     = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_LTE    = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_LSH    = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_GT     = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_GTE    = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_RSH    = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_EQ     = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_NEQ    = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_ERROR  = 5'd24;

   // characters with a role of their own
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_INT,
      MODE_FRAC,
      MODE_LT,
      MODE_GT,
      MODE_EQ,
      MODE_BANG
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [POS_BITS-1:0] pos;
      logic [POS_BITS-1:0] line;
      logic [POS_BITS-1:0] column;
      logic [POS_BITS-1:0] pstart;
      logic [POS_BITS-1:0] plen;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '{
      mode:   MODE_IDLE,
      pos:    '0,
      line:   POS_BITS'(1),
      column: POS_BITS'(1),
      pstart: '0,
      plen:   '0
   };

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [POS_BITS-1:0]  start;
      logic [POS_BITS-1:0]  length;
      logic [POS_BITS-1:0]  line;
      logic [POS_BITS-1:0]  column;
      logic                 last;
   } token_type;

   // up to two tokens from one byte, second only when first is present
   typedef struct packed {
      logic      first_valid;
      logic      second_valid;
      token_type first;
      token_type second;
   } push_type;

   function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      unique case (c)
         CH_COLON:  k = KIND_COLON;
         CH_LBRACK: k = KIND_LBRACK;
         CH_RBRACK: k = KIND_RBRACK;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         CH_DOT:    k = KIND_DOT;
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_SLASH:  k = KIND_SLASH;
         CH_PCT:    k = KIND_PCT;
         CH_CARET:  k = KIND_CARET;
         default:   k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### hdl/etl_core.sv
`timescale 1ns / 1ps
`default_nettype none

module etl_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        char_in,
   output etl_pkg::push_type      push
);

   typedef struct packed {
      etl_pkg::lex_state_type s;
      logic                   v;
      etl_pkg::token_type     tok;
   } idle_res_type;

   etl_pkg::lex_state_type state_ff, state_in;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= etl_pkg::CH_ZERO) && (c <= etl_pkg::CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= etl_pkg::CH_LO_A) && (c <= etl_pkg::CH_LO_Z)) ||
             ((c >= etl_pkg::CH_UP_A) && (c <= etl_pkg::CH_UP_Z));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == etl_pkg::CH_SPACE) || ((c >= etl_pkg::CH_TAB) && (c <= etl_pkg::CH_CR));
   endfunction

   // advance position, line and column over one byte
   function automatic etl_pkg::lex_state_type consume(input etl_pkg::lex_state_type s,
                                                      input logic [7:0] c);
      etl_pkg::lex_state_type r;
      r = s;
      r.pos = s.pos + etl_pkg::POS_BITS'(1);
      if (c == etl_pkg::CH_NL) begin
         if (s.line != etl_pkg::POS_MAX) r.line = s.line + etl_pkg::POS_BITS'(1);
         r.column = etl_pkg::POS_BITS'(1);
      end else if (s.column != etl_pkg::POS_MAX) begin
         r.column = s.column + etl_pkg::POS_BITS'(1);
      end
      return r;
   endfunction

   function automatic etl_pkg::token_type make_tok(input logic [etl_pkg::KIND_BITS-1:0] k,
                                                   input logic [etl_pkg::POS_BITS-1:0] start,
                                                   input logic [etl_pkg::POS_BITS-1:0] len,
                                                   input etl_pkg::lex_state_type s);
      etl_pkg::token_type t;
      t.kind   = k;
      t.start  = start;
      t.length = len;
      t.line   = s.line;
      t.column = s.column;
      t.last   = 1'b0;
      return t;
   endfunction

   // byte seen with nothing pending (idle or in a comment)
   function automatic idle_res_type idle_step(input etl_pkg::lex_state_type s,
                                              input logic [7:0] c);
      idle_res_type r;
      r.s   = s;
      r.v   = 1'b0;
      r.tok = '0;
      if (c == etl_pkg::CH_NUL) begin
         r.v   = 1'b1;
         r.tok = make_tok(etl_pkg::KIND_END, s.pos, '0, s);
         r.s   = etl_pkg::LEX_RESET;
      end else if (s.mode == etl_pkg::MODE_COMMENT) begin
         r.s = consume(s, c);
         if (c == etl_pkg::CH_NL) r.s.mode = etl_pkg::MODE_IDLE;
      end else begin
         r.s        = s;
         r.s.pstart = s.pos;
         r.s.plen   = etl_pkg::POS_BITS'(1);
         r.s        = consume(r.s, c);
         if (is_space(c)) begin
            r.v = 1'b0;
         end else if (c == etl_pkg::CH_AT) begin
            r.s.mode = etl_pkg::MODE_COMMENT;
         end else if (is_digit(c)) begin
            r.s.mode = etl_pkg::MODE_INT;
         end else if (is_alpha(c)) begin
            r.v   = 1'b1;
            r.tok = make_tok(etl_pkg::KIND_LETTER, s.pos, etl_pkg::POS_BITS'(1), r.s);
         end else if (c == etl_pkg::CH_LT) begin
            r.s.mode = etl_pkg::MODE_LT;
         end else if (c == etl_pkg::CH_GT) begin
            r.s.mode = etl_pkg::MODE_GT;
         end else if (c == etl_pkg::CH_EQ) begin
            r.s.mode = etl_pkg::MODE_EQ;
         end else if (c == etl_pkg::CH_BANG) begin
            r.s.mode = etl_pkg::MODE_BANG;
         end else begin
            r.v   = 1'b1;
            r.tok = make_tok(etl_pkg::single_kind(c), s.pos, etl_pkg::POS_BITS'(1), r.s);
         end
      end
      return r;
   endfunction

   idle_res_type                   idle_a, idle_b;
   etl_pkg::lex_state_type         after_a, flush_s;
   etl_pkg::token_type             tok_a;
   logic                           valid_a, flush;
   logic                           pair_ok;
   logic [etl_pkg::KIND_BITS-1:0]  pair_kind, alone_kind;

   always_comb begin
      after_a    = state_ff;
      tok_a      = '0;
      valid_a    = 1'b0;
      flush      = 1'b0;
      pair_ok    = 1'b0;
      pair_kind  = etl_pkg::KIND_ERROR;
      alone_kind = etl_pkg::KIND_ERROR;
      idle_a     = idle_step(state_ff, char_in);
      unique case (state_ff.mode)
         etl_pkg::MODE_INT, etl_pkg::MODE_FRAC: begin
            if (is_digit(char_in) ||
                (char_in == etl_pkg::CH_DOT && state_ff.mode == etl_pkg::MODE_INT)) begin
               after_a = consume(state_ff, char_in);
               if (char_in == etl_pkg::CH_DOT) after_a.mode = etl_pkg::MODE_FRAC;
               if (state_ff.plen != etl_pkg::POS_MAX) begin
                  after_a.plen = state_ff.plen + etl_pkg::POS_BITS'(1);
               end
            end else begin
               valid_a = 1'b1;
               tok_a   = make_tok(etl_pkg::KIND_NUMBER, state_ff.pstart, state_ff.plen,
                                  state_ff);
               flush   = 1'b1;
            end
         end
         etl_pkg::MODE_LT, etl_pkg::MODE_GT, etl_pkg::MODE_EQ, etl_pkg::MODE_BANG: begin
            if (state_ff.mode == etl_pkg::MODE_LT) begin
               alone_kind = etl_pkg::KIND_LT;
               if (char_in == etl_pkg::CH_LT) begin
                  pair_ok = 1'b1; pair_kind = etl_pkg::KIND_LSH;
               end else if (char_in == etl_pkg::CH_EQ) begin
                  pair_ok = 1'b1; pair_kind = etl_pkg::KIND_LTE;
               end
            end else if (state_ff.mode == etl_pkg::MODE_GT) begin
               alone_kind = etl_pkg::KIND_GT;
               if (char_in == etl_pkg::CH_GT) begin
                  pair_ok = 1'b1; pair_kind = etl_pkg::KIND_RSH;
               end else if (char_in == etl_pkg::CH_EQ) begin
                  pair_ok = 1'b1; pair_kind = etl_pkg::KIND_GTE;
               end
            end else if (char_in == etl_pkg::CH_EQ) begin
               pair_ok   = 1'b1;
               pair_kind = (state_ff.mode == etl_pkg::MODE_EQ) ? etl_pkg::KIND_EQ
                                                               : etl_pkg::KIND_NEQ;
            end
            valid_a = 1'b1;
            if (pair_ok) begin
               after_a      = consume(state_ff, char_in);
               after_a.mode = etl_pkg::MODE_IDLE;
               tok_a        = make_tok(pair_kind, state_ff.pstart, etl_pkg::POS_BITS'(2),
                                       after_a);
            end else begin
               tok_a = make_tok(alone_kind, state_ff.pstart, etl_pkg::POS_BITS'(1), state_ff);
               flush = 1'b1;
            end
         end
         default: begin
            after_a = idle_a.s;
            valid_a = idle_a.v;
            tok_a   = idle_a.tok;
         end
      endcase

      // the byte that flushed a pending token is then lexed from idle
      flush_s      = after_a;
      flush_s.mode = etl_pkg::MODE_IDLE;
      idle_b       = idle_step(flush_s, char_in);

      state_in          = flush ? idle_b.s : after_a;
      push.first_valid  = step & valid_a;
      push.second_valid = step & flush & idle_b.v;
      push.first        = tok_a;
      push.first.last   = ~(flush & idle_b.v);
      push.second       = idle_b.tok;
      push.second.last  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etl_pkg::LEX_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hdl/etl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module etl_fifo (
   input  wire logic          clock,
   input  wire logic          reset,
   input  etl_pkg::push_type  push,
   output logic               room,
   output logic               out_valid,
   input  wire logic          out_ready,
   output etl_pkg::token_type out_tok
);

   etl_pkg::token_type entry_ff [etl_pkg::QUEUE_DEPTH];
   logic [etl_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [etl_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [etl_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic       pop;
   logic [1:0] n_push;

   assign out_valid = (count_ff != '0);
   assign out_tok   = entry_ff[rd_ptr_ff];
   // space for the two tokens one byte can make
   assign room      = (count_ff <=
                       (etl_pkg::QUEUE_PTR_BITS+1)'(etl_pkg::QUEUE_DEPTH - 2));
   assign pop       = out_valid & out_ready;

   always_comb begin
      n_push    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      wr_ptr_in = wr_ptr_ff + etl_pkg::QUEUE_PTR_BITS'(n_push);
      rd_ptr_in = rd_ptr_ff + etl_pkg::QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + (etl_pkg::QUEUE_PTR_BITS+1)'(n_push)
                           - (etl_pkg::QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) entry_ff[wr_ptr_ff] <= push.first;
      if (push.second_valid) begin
         entry_ff[wr_ptr_ff + etl_pkg::QUEUE_PTR_BITS'(1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

### hdl/expression_token_lexer.sv
// expression token lexer
// requests on the req_ channel carry one source byte each (req_tdata), byte
// zero ends the source; the block skips whitespace and '@' comments and sends
// tokens on the rsp_ channel, each with its kind on rsp_tuser and the start
// offset, length and the line and column just after it on rsp_tdata;
// rsp_tlast marks the last token of a byte
// a byte taken into the input register is lexed from there once the queue has
// room, and its tokens are written to the queue, which drives rsp_tvalid
// throughput: one request per cycle while the receiver keeps up; a byte that
// flushes a pending token gives two tokens, and the output side moves one
// token per cycle while rsp_tready is high, out of a four-entry queue
// the lexer steps only when that queue has room for two tokens, so a stalled
// receiver fills the queue and then the input register, and req_tready falls
// nothing is lost or repeated under stalls on either side
// reset clears the queue and returns the lexer to idle with offset 0, line 1
// and column 1; after an end token the lexer returns to that state by itself
`timescale 1ns / 1ps
`default_nettype none

module expression_token_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // start_offset[15:0], token_length[31:16], line_number[47:32],
   // column_number[63:48]
   output logic [63:0]      rsp_tdata,
   output logic [4:0]       rsp_tuser,   // token_kind
   output logic             rsp_tlast    // last_of_run
);

   // input register holding one request byte
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;

   logic               room;
   logic               step;
   logic               req_fire;
   etl_pkg::push_type  push;
   etl_pkg::token_type out_tok;

   // lex the held byte when the queue can take what it makes
   assign step       = in_valid_ff & room;
   assign req_tready = ~in_valid_ff | step;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) in_char_ff <= req_tdata;
   end

   // mode, position and counters; up to two tokens per byte
   etl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .char_in (in_char_ff),
      .push    (push)
   );

   // result queue, one token per cycle toward the receiver while it is ready
   etl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok)
   );

   assign rsp_tdata = {out_tok.column, out_tok.line, out_tok.length, out_tok.start};
   assign rsp_tuser = out_tok.kind;
   assign rsp_tlast = out_tok.last;

endmodule

`default_nettype wire

### verif/tb_expression_token_lexer.sv
`timescale 1ns / 1ps

module tb_expression_token_lexer;

   // cycles with no request and no token accepted before the run is called hung
   localparam int QUIET_LIMIT = 2000;
   // long receiver hold-off, well past the depth of the token queue
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // char_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   // start_offset[15:0], token_length[31:16], line_number[47:32],
   // column_number[63:48]
   logic [63:0] rsp_tdata;
   logic [4:0]  rsp_tuser;    // token_kind
   logic        rsp_tlast;    // last_of_run

   expression_token_lexer dut (.*);

   // ---------------------------------------------------------------
   // lexer prediction: own copy of the scan state
   // ---------------------------------------------------------------
   etl_pkg::mode_type            lex_mode;
   logic [etl_pkg::POS_BITS-1:0] lex_pos;
   logic [etl_pkg::POS_BITS-1:0] lex_line;
   logic [etl_pkg::POS_BITS-1:0] lex_col;
   logic [etl_pkg::POS_BITS-1:0] tok_start;
   logic [etl_pkg::POS_BITS-1:0] tok_len;

   // kind of every byte that forms a token on its own
   logic [etl_pkg::KIND_BITS-1:0] op_table [256];

   etl_pkg::token_type byte_tokens[$];       // tokens caused by the byte being lexed
   etl_pkg::token_type expected_tokens[$];   // tokens still owed by the block

   int unsigned failures;
   int unsigned sent_count;
   int          req_idle_max;
   int          rsp_idle_max;
   int          rsp_hold_cycles;

   function automatic void clear_scan();
      lex_mode  = etl_pkg::MODE_IDLE;
      lex_pos   = '0;
      lex_line  = etl_pkg::POS_BITS'(1);
      lex_col   = etl_pkg::POS_BITS'(1);
      tok_start = '0;
      tok_len   = '0;
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == etl_pkg::CH_SPACE || (c >= etl_pkg::CH_TAB && c <= etl_pkg::CH_CR);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= etl_pkg::CH_ZERO && c <= etl_pkg::CH_NINE;
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= etl_pkg::CH_UP_A && c <= etl_pkg::CH_UP_Z) ||
             (c >= etl_pkg::CH_LO_A && c <= etl_pkg::CH_LO_Z);
   endfunction

   // step past one source byte; line and column stick at the top value
   function automatic void advance(logic [7:0] c);
      lex_pos = lex_pos + 1'b1;
      if (c == etl_pkg::CH_NL) begin
         if (lex_line != etl_pkg::POS_MAX) lex_line = lex_line + 1'b1;
         lex_col = etl_pkg::POS_BITS'(1);
      end else if (lex_col != etl_pkg::POS_MAX) begin
         lex_col = lex_col + 1'b1;
      end
   endfunction

   function automatic void push_token(logic [etl_pkg::KIND_BITS-1:0] kind,
                                      logic [etl_pkg::POS_BITS-1:0] start,
                                      logic [etl_pkg::POS_BITS-1:0] len);
      etl_pkg::token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = len;
      t.line   = lex_line;
      t.column = lex_col;
      t.last   = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   // byte seen with nothing pending (idle or inside a comment)
   function automatic void start_token(logic [7:0] c);
      if (c == etl_pkg::CH_NUL) begin
         push_token(etl_pkg::KIND_END, lex_pos, '0);
         clear_scan();
         return;
      end
      if (lex_mode == etl_pkg::MODE_COMMENT) begin
         if (c == etl_pkg::CH_NL) lex_mode = etl_pkg::MODE_IDLE;
         advance(c);
         return;
      end
      tok_start = lex_pos;
      tok_len   = etl_pkg::POS_BITS'(1);
      advance(c);
      if (is_space(c)) return;
      if (c == etl_pkg::CH_AT) lex_mode = etl_pkg::MODE_COMMENT;
      else if (is_digit(c)) lex_mode = etl_pkg::MODE_INT;
      else if (is_alpha(c)) push_token(etl_pkg::KIND_LETTER, tok_start, etl_pkg::POS_BITS'(1));
      else if (c == etl_pkg::CH_LT) lex_mode = etl_pkg::MODE_LT;
      else if (c == etl_pkg::CH_GT) lex_mode = etl_pkg::MODE_GT;
      else if (c == etl_pkg::CH_EQ) lex_mode = etl_pkg::MODE_EQ;
      else if (c == etl_pkg::CH_BANG) lex_mode = etl_pkg::MODE_BANG;
      else push_token(op_table[c], tok_start, etl_pkg::POS_BITS'(1));
   endfunction

   // one accepted request: work out its tokens and queue them
   function automatic void lex_byte(logic [7:0] c);
      bit                            flush;
      logic [etl_pkg::KIND_BITS-1:0] pair;
      logic [etl_pkg::KIND_BITS-1:0] alone;
      int                            n;
      flush = 1'b0;
      pair  = etl_pkg::KIND_ERROR;
      alone = etl_pkg::KIND_ERROR;
      case (lex_mode)
         etl_pkg::MODE_INT, etl_pkg::MODE_FRAC: begin
            if (is_digit(c) || (c == etl_pkg::CH_DOT && lex_mode == etl_pkg::MODE_INT)) begin
               if (c == etl_pkg::CH_DOT) lex_mode = etl_pkg::MODE_FRAC;
               advance(c);
               if (tok_len != etl_pkg::POS_MAX) tok_len = tok_len + 1'b1;
            end else begin
               push_token(etl_pkg::KIND_NUMBER, tok_start, tok_len);
               flush = 1'b1;
            end
         end
         etl_pkg::MODE_LT, etl_pkg::MODE_GT, etl_pkg::MODE_EQ, etl_pkg::MODE_BANG: begin
            case (lex_mode)
               etl_pkg::MODE_LT: begin
                  alone = etl_pkg::KIND_LT;
                  if (c == etl_pkg::CH_LT) pair = etl_pkg::KIND_LSH;
                  else if (c == etl_pkg::CH_EQ) pair = etl_pkg::KIND_LTE;
               end
               etl_pkg::MODE_GT: begin
                  alone = etl_pkg::KIND_GT;
                  if (c == etl_pkg::CH_GT) pair = etl_pkg::KIND_RSH;
                  else if (c == etl_pkg::CH_EQ) pair = etl_pkg::KIND_GTE;
               end
               etl_pkg::MODE_EQ: if (c == etl_pkg::CH_EQ) pair = etl_pkg::KIND_EQ;
               default: if (c == etl_pkg::CH_EQ) pair = etl_pkg::KIND_NEQ;
            endcase
            if (pair != etl_pkg::KIND_ERROR) begin
               // the second byte belongs to the token, so it counts first
               advance(c);
               push_token(pair, tok_start, etl_pkg::POS_BITS'(2));
               lex_mode = etl_pkg::MODE_IDLE;
            end else begin
               push_token(alone, tok_start, etl_pkg::POS_BITS'(1));
               flush = 1'b1;
            end
         end
         default: start_token(c);
      endcase
      // the flushing byte is then lexed as if nothing had been pending
      if (flush) begin
         lex_mode = etl_pkg::MODE_IDLE;
         start_token(c);
      end
      n = byte_tokens.size();
      if (n > 0) byte_tokens[n-1].last = 1'b1;
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
      byte_tokens.delete();
   endfunction

   // ---------------------------------------------------------------
   // clock, watchdog
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // token receiver and checker
   // ---------------------------------------------------------------
   function automatic void compare_field(string name, int unsigned want,
                                         int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_token();
      etl_pkg::token_type got;
      etl_pkg::token_type want;
      got.kind   = rsp_tuser;
      got.start  = rsp_tdata[15:0];
      got.length = rsp_tdata[31:16];
      got.line   = rsp_tdata[47:32];
      got.column = rsp_tdata[63:48];
      got.last   = rsp_tlast;
      if (expected_tokens.size() == 0) begin
         $error("token_kind: expected none, got %0d at offset %0d", got.kind, got.start);
         failures++;
         return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_kind", want.kind, got.kind);
      compare_field("start_offset", want.start, got.start);
      compare_field("token_length", want.length, got.length);
      compare_field("line_number", want.line, got.line);
      compare_field("column_number", want.column, got.column);
      compare_field("last_of_run", want.last, got.last);
   endfunction

   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         // a requested hold-off takes the place of the random stall once
         if (rsp_hold_cycles > 0) stall = rsp_hold_cycles;
         else stall = $urandom_range(0, rsp_idle_max);
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         check_token();
      end
   end

   // ---------------------------------------------------------------
   // request sender
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] c);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      lex_byte(c);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   // every single-byte operator, letter extremes
   task automatic test_single_char_tokens();
      send_text("a:[](),.+-*/%^Z");
      send_byte(etl_pkg::CH_NUL);
   endtask

   // each two-byte operator, lone < and > flushed by a letter,
   // and a pending < closed by the end of source
   task automatic test_two_char_operators();
      send_text("<<<=<a>>>=>b==!=<");
      send_byte(etl_pkg::CH_NUL);
   endtask

   // lone = and !, high and unknown bytes, numbers with fractions and a
   // second dot, whitespace other than space and newline, comments, end
   // inside a comment, end inside a number, empty source
   task automatic test_errors_numbers_comments();
      send_text("=!");
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_text("0.5\t1..9");
      send_byte(8'h0B);
      send_byte(8'h0C);
      send_text("\r@z\n7");
      send_byte(etl_pkg::CH_NUL);
      send_text("@x");
      send_byte(etl_pkg::CH_NUL);
      send_byte(etl_pkg::CH_NUL);
   endtask

   // mostly well-formed expressions with random content, some noise
   task automatic test_random_sources(input int unsigned total);
      logic [7:0] op_chars [13] = '{etl_pkg::CH_COLON, etl_pkg::CH_LBRACK,
                                    etl_pkg::CH_RBRACK, etl_pkg::CH_LPAREN,
                                    etl_pkg::CH_RPAREN, etl_pkg::CH_COMMA,
                                    etl_pkg::CH_DOT, etl_pkg::CH_PLUS,
                                    etl_pkg::CH_MINUS, etl_pkg::CH_STAR,
                                    etl_pkg::CH_SLASH, etl_pkg::CH_PCT,
                                    etl_pkg::CH_CARET};
      logic [7:0] cmp_chars [4] = '{etl_pkg::CH_LT, etl_pkg::CH_GT,
                                    etl_pkg::CH_EQ, etl_pkg::CH_BANG};
      int unsigned stop_at;
      int unsigned source_end;
      int pick;
      logic [7:0] c;
      stop_at = sent_count + total;
      while (sent_count < stop_at) begin
         // some sources run without any idling on either side
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         source_end = sent_count + $urandom_range(5, 60);
         while (sent_count < source_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               repeat ($urandom_range(1, 4)) begin
                  send_byte(8'(etl_pkg::CH_ZERO + $urandom_range(0, 9)));
               end
               if ($urandom_range(0, 2) == 0) begin
                  send_byte(etl_pkg::CH_DOT);
                  repeat ($urandom_range(0, 3)) begin
                     send_byte(8'(etl_pkg::CH_ZERO + $urandom_range(0, 9)));
                  end
               end
            end else if (pick < 40) begin
               c = ($urandom_range(0, 1) == 1) ? etl_pkg::CH_LO_A : etl_pkg::CH_UP_A;
               send_byte(8'(c + $urandom_range(0, 25)));
            end else if (pick < 55) begin
               send_byte(op_chars[$urandom_range(0, 12)]);
            end else if (pick < 68) begin
               send_byte(cmp_chars[$urandom_range(0, 3)]);
               if ($urandom_range(0, 3) != 0) send_byte(cmp_chars[$urandom_range(0, 3)]);
            end else if (pick < 81) begin
               repeat ($urandom_range(1, 3)) begin
                  c = ($urandom_range(0, 2) == 0) ? etl_pkg::CH_SPACE
                                                  : 8'(etl_pkg::CH_TAB + $urandom_range(0, 4));
                  send_byte(c);
               end
            end else if (pick < 88) begin
               send_byte(etl_pkg::CH_AT);
               repeat ($urandom_range(0, 6)) begin
                  c = 8'($urandom_range(1, 255));
                  if (c == etl_pkg::CH_NL) c = etl_pkg::CH_SPACE;
                  send_byte(c);
               end
               if ($urandom_range(0, 4) != 0) send_byte(etl_pkg::CH_NL);
            end else begin
               send_byte(8'($urandom_range(1, 255)));
            end
         end
         send_byte(etl_pkg::CH_NUL);
      end
      req_idle_max = 11;
      rsp_idle_max = 11;
   endtask

   // receiver holds off while bytes that each flush a number keep coming
   task automatic test_output_backpressure();
      req_idle_max    = 0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (40) begin
         send_byte(8'(etl_pkg::CH_ZERO + $urandom_range(0, 9)));
         send_byte(8'(etl_pkg::CH_LO_A + $urandom_range(0, 25)));
      end
      send_byte(etl_pkg::CH_NUL);
      req_idle_max = 11;
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      foreach (op_table[i]) op_table[i] = etl_pkg::KIND_ERROR;
      op_table[etl_pkg::CH_COLON]  = etl_pkg::KIND_COLON;
      op_table[etl_pkg::CH_LBRACK] = etl_pkg::KIND_LBRACK;
      op_table[etl_pkg::CH_RBRACK] = etl_pkg::KIND_RBRACK;
      op_table[etl_pkg::CH_LPAREN] = etl_pkg::KIND_LPAREN;
      op_table[etl_pkg::CH_RPAREN] = etl_pkg::KIND_RPAREN;
      op_table[etl_pkg::CH_COMMA]  = etl_pkg::KIND_COMMA;
      op_table[etl_pkg::CH_DOT]    = etl_pkg::KIND_DOT;
      op_table[etl_pkg::CH_PLUS]   = etl_pkg::KIND_PLUS;
      op_table[etl_pkg::CH_MINUS]  = etl_pkg::KIND_MINUS;
      op_table[etl_pkg::CH_STAR]   = etl_pkg::KIND_STAR;
      op_table[etl_pkg::CH_SLASH]  = etl_pkg::KIND_SLASH;
      op_table[etl_pkg::CH_PCT]    = etl_pkg::KIND_PCT;
      op_table[etl_pkg::CH_CARET]  = etl_pkg::KIND_CARET;
      clear_scan();
      failures        = 0;
      sent_count      = 0;
      req_idle_max    = 11;
      rsp_idle_max    = 11;
      rsp_hold_cycles = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_single_char_tokens();
      test_two_char_operators();
      test_errors_numbers_comments();
      test_output_backpressure();
      test_random_sources(650);

      @(negedge clock) req_tvalid <= 1'b0;
      wait (expected_tokens.size() == 0);
      // input register and token queue: give any stray token time to show
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
hdl/etl_pkg.sv
hdl/etl_core.sv
hdl/etl_fifo.sv
hdl/expression_token_lexer.sv
verif/tb_expression_token_lexer.sv
